// ===== rtl/core/ufe_pkg.sv =====
// Shared types, codes and header arithmetic for the frame encapsulator.
package ufe_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LINK_ID      = 2'd0;
  localparam logic [1:0] REG_TAG_ENABLE   = 2'd1;
  localparam logic [1:0] REG_TAG_VID      = 2'd2;
  localparam logic [1:0] REG_NETWORK_BYTE = 2'd3;

  // Command kinds passed from the front end to the back end.
  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_ERR   = 2'd2;

  // Fixed frame overhead: Ethernet 14, IPv4 20, UDP 8, trailer 1.
  localparam int unsigned FRAME_OVERHEAD = 43;
  localparam int unsigned TAG_BYTES      = 4;

  typedef struct packed {
    logic [15:0] link_id;
    logic        tag_enable;
    logic [11:0] tag_vid;
    logic [7:0]  network_byte;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [10:0] length;
    logic [7:0]  seq;
  } cmd_t;

  // Ones-complement IPv4 header checksum; every header word but the total
  // length and the low half of the destination address is fixed.
  function automatic logic [15:0] hdr_checksum(input logic [10:0] length,
                                               input logic [15:0] link_id);
    logic [17:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    sum   = 18'h2262e + 18'd28 + {7'd0, length} + {2'd0, link_id};
    fold1 = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    return ~fold2;
  endfunction

endpackage

// ===== rtl/core/udp_ipv4_vlan_frame_encapsulator.sv =====
// Top level of the Ethernet, 802.1Q, IPv4 and UDP frame encapsulator.
// The block takes payload bytes one beat at a time on the slave stream and
// sends complete frames on the master stream. The first payload beat of a
// frame (tuser high) also carries the payload length and the sequence byte.
// For that beat the block sends a 42-byte header (46 bytes when the VLAN tag
// is enabled), then the byte itself; every later payload beat passes through
// as one output beat, and the beat marked tlast is followed by the sequence
// byte with tlast set on the output. A frame whose total size would exceed
// MAX_FRAME produces a single output beat with tuser and tlast high and a
// zero data byte, and the rest of that frame's input beats are discarded.
// Beats outside an open frame are discarded. The front end accepts one beat
// per cycle whenever its command queue (QUEUE_DEPTH entries) has room; while
// the output is ready the back end sends one output beat per cycle, so a
// steady payload stream runs at one byte per cycle; each frame's header adds
// 42 or 46 output beats and the trailer one more. During a header burst the
// input is held off once the queue fills. The output beat is held in a
// register, so input beats flow into the queue while a finished beat waits,
// until it fills. Configuration registers sit on a small APB port; the user
// must write them only while no frame is in flight; the block does not check.
module udp_ipv4_vlan_frame_encapsulator #(
  parameter int MAX_FRAME   = 1518,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Payload input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: data_byte [7:0], payload_length [18:8],
  // sequence_byte [26:19], zero padding [31:27].
  input  logic [31:0] s_axis_tdata,
  // Fields from bit 0: first_byte.
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  // Frame output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: out_byte.
  output logic [7:0]  m_axis_tdata,
  // Fields from bit 0: frame_error.
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ufe_pkg::*;

  cfg_t cfg;
  logic cfg_write;
  logic queue_ready;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // The register file completes every access in its first access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_LINK_ID:      cfg.link_id      <= pwdata[15:0];
        REG_TAG_ENABLE:   cfg.tag_enable   <= pwdata[0];
        REG_TAG_VID:      cfg.tag_vid      <= pwdata[11:0];
        REG_NETWORK_BYTE: cfg.network_byte <= pwdata[7:0];
        default:          cfg.link_id      <= cfg.link_id;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LINK_ID:      prdata = {16'd0, cfg.link_id};
      REG_TAG_ENABLE:   prdata = {31'd0, cfg.tag_enable};
      REG_TAG_VID:      prdata = {20'd0, cfg.tag_vid};
      REG_NETWORK_BYTE: prdata = {24'd0, cfg.network_byte};
      default:          prdata = 32'd0;
    endcase
  end

  // Front end: frame tracking and the size check.
  ufe_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .data_byte      (s_axis_tdata[7:0]),
    .first_byte     (s_axis_tuser),
    .last_byte      (s_axis_tlast),
    .payload_length (s_axis_tdata[18:8]),
    .sequence_byte  (s_axis_tdata[26:19]),
    .tag_enable     (cfg.tag_enable),
    .queue_ready    (queue_ready),
    .push           (push),
    .cmd            (push_cmd)
  );

  // Commands wait here while the back end is busy with a header.
  ufe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: header generation, payload pass-through and trailer.
  ufe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_error  (m_axis_tuser)
  );

endmodule

// ===== rtl/core/ufe_front.sv =====
// Front end: takes input beats, tracks frame state and issues commands.
module ufe_front #(
  parameter int MAX_FRAME = 1518
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          first_byte,
  input  logic          last_byte,
  input  logic [10:0]   payload_length,
  input  logic [7:0]    sequence_byte,
  input  logic          tag_enable,
  input  logic          queue_ready,
  output logic          push,
  output ufe_pkg::cmd_t cmd
);
  import ufe_pkg::*;

  localparam int MAX_W = $clog2(MAX_FRAME + 1);
  localparam int TOT_W = (MAX_W > 12) ? MAX_W : 12;

  logic             in_frame;
  logic             in_frame_next;
  logic             dropping;
  logic             dropping_next;
  logic             accept;
  logic [TOT_W-1:0] total;
  logic             oversize;

  assign in_ready = queue_ready;
  assign accept   = in_valid && in_ready;

  assign total = TOT_W'(payload_length) + TOT_W'(FRAME_OVERHEAD)
               + (tag_enable ? TOT_W'(TAG_BYTES) : TOT_W'(0));
  assign oversize = total > TOT_W'(MAX_FRAME);

  always_comb begin
    in_frame_next = in_frame;
    dropping_next = dropping;
    push          = 1'b0;
    cmd.kind      = CMD_DATA;
    cmd.data      = data_byte;
    cmd.last      = last_byte;
    cmd.length    = payload_length;
    cmd.seq       = sequence_byte;
    if (accept) begin
      if (first_byte) begin
        push = 1'b1;
        if (oversize) begin
          cmd.kind      = CMD_ERR;
          in_frame_next = 1'b0;
          dropping_next = !last_byte;
        end else begin
          cmd.kind      = CMD_START;
          in_frame_next = !last_byte;
          dropping_next = 1'b0;
        end
      end else if (dropping) begin
        if (last_byte) begin
          dropping_next = 1'b0;
        end
      end else if (in_frame) begin
        push = 1'b1;
        if (last_byte) begin
          in_frame_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      dropping <= 1'b0;
    end else begin
      in_frame <= in_frame_next;
      dropping <= dropping_next;
    end
  end

  // A frame cannot be open and being dropped at the same time.
  a_front_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_frame && dropping))
    else $error("front end both in a frame and dropping");

endmodule

// ===== rtl/core/ufe_queue.sv =====
// Command queue between the front end and the back end.
module ufe_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ufe_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output ufe_pkg::cmd_t head_cmd
);
  import ufe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = count != CNT_W'(DEPTH);
  assign head_valid = count != CNT_W'(0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CNT_W'(DEPTH)) || pop)
    else $error("command pushed into a full queue");

  a_queue_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond its depth");

endmodule

// ===== rtl/core/ufe_back.sv =====
// Back end: expands commands into header, payload and trailer beats.
module ufe_back (
  input  logic          clk,
  input  logic          rst,
  input  ufe_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  ufe_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_error
);
  import ufe_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HDR   = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;
  localparam logic [1:0] ST_TRAIL = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [5:0]  hdr_idx;
  logic [5:0]  hdr_idx_next;
  logic [5:0]  last_idx;
  logic [5:0]  eff_idx;
  logic        latch;
  logic        adv;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_end;
  logic        emit_err;
  logic [7:0]  hdr_byte;
  logic [7:0]  cur_data;
  logic        cur_last;
  logic [10:0] length;
  logic [7:0]  seq;
  logic [15:0] checksum;
  logic [11:0] ip_len;
  logic [11:0] udp_len;

  assign adv      = !out_valid || out_ready;
  assign last_idx = cfg.tag_enable ? 6'd45 : 6'd41;
  assign ip_len   = {1'b0, length} + 12'd28;
  assign udp_len  = {1'b0, length} + 12'd8;
  assign eff_idx  = (cfg.tag_enable && hdr_idx >= 6'd16) ? hdr_idx - 6'd4 : hdr_idx;

  // Header byte at the current index; tag bytes sit after the source MAC.
  always_comb begin
    hdr_byte = 8'h00;
    if (cfg.tag_enable && hdr_idx >= 6'd12 && hdr_idx < 6'd16) begin
      unique case (hdr_idx[1:0])
        2'd0:    hdr_byte = 8'h81;
        2'd1:    hdr_byte = 8'h00;
        2'd2:    hdr_byte = {4'h0, cfg.tag_vid[11:8]};
        default: hdr_byte = cfg.tag_vid[7:0];
      endcase
    end else begin
      unique case (eff_idx)
        6'd0:    hdr_byte = 8'h03;
        6'd4:    hdr_byte = cfg.link_id[15:8];
        6'd5:    hdr_byte = cfg.link_id[7:0];
        6'd6:    hdr_byte = 8'h02;
        6'd11:   hdr_byte = cfg.network_byte;
        6'd12:   hdr_byte = 8'h08;
        6'd14:   hdr_byte = 8'h45;
        6'd16:   hdr_byte = {4'h0, ip_len[11:8]};
        6'd17:   hdr_byte = ip_len[7:0];
        6'd18:   hdr_byte = 8'hd4;
        6'd19:   hdr_byte = 8'h3b;
        6'd22:   hdr_byte = 8'h01;
        6'd23:   hdr_byte = 8'h11;
        6'd24:   hdr_byte = checksum[15:8];
        6'd25:   hdr_byte = checksum[7:0];
        6'd26:   hdr_byte = 8'h0a;
        6'd27:   hdr_byte = 8'h01;
        6'd28:   hdr_byte = 8'h21;
        6'd29:   hdr_byte = 8'h01;
        6'd30:   hdr_byte = 8'he0;
        6'd31:   hdr_byte = 8'he0;
        6'd32:   hdr_byte = cfg.link_id[15:8];
        6'd33:   hdr_byte = cfg.link_id[7:0];
        6'd35:   hdr_byte = 8'd100;
        6'd37:   hdr_byte = 8'd100;
        6'd38:   hdr_byte = {4'h0, udp_len[11:8]};
        6'd39:   hdr_byte = udp_len[7:0];
        default: hdr_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    state_next   = state;
    hdr_idx_next = hdr_idx;
    pop          = 1'b0;
    latch        = 1'b0;
    emit         = 1'b0;
    emit_byte    = 8'h00;
    emit_end     = 1'b0;
    emit_err     = 1'b0;
    if (adv) begin
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            pop  = 1'b1;
            emit = 1'b1;
            unique case (head_cmd.kind)
              CMD_ERR: begin
                emit_end = 1'b1;
                emit_err = 1'b1;
              end
              CMD_DATA: begin
                emit_byte = head_cmd.data;
                if (head_cmd.last) begin
                  state_next = ST_TRAIL;
                end
              end
              CMD_START: begin
                latch        = 1'b1;
                emit_byte    = 8'h03;
                hdr_idx_next = 6'd1;
                state_next   = ST_HDR;
              end
              default: emit = 1'b0;
            endcase
          end
        end
        ST_HDR: begin
          emit      = 1'b1;
          emit_byte = hdr_byte;
          if (hdr_idx == last_idx) begin
            state_next = ST_DATA;
          end else begin
            hdr_idx_next = hdr_idx + 6'd1;
          end
        end
        ST_DATA: begin
          emit       = 1'b1;
          emit_byte  = cur_data;
          state_next = cur_last ? ST_TRAIL : ST_IDLE;
        end
        default: begin
          emit       = 1'b1;
          emit_byte  = seq;
          emit_end   = 1'b1;
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      cur_data <= head_cmd.data;
      cur_last <= head_cmd.last;
      length   <= head_cmd.length;
      seq      <= head_cmd.seq;
      checksum <= hdr_checksum(head_cmd.length, cfg.link_id);
    end
    if (adv) begin
      out_byte  <= emit_byte;
      out_last  <= emit_end;
      out_error <= emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hdr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      hdr_idx <= hdr_idx_next;
      if (adv) begin
        out_valid <= emit;
      end
    end
  end

  a_back_error_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_last)
    else $error("error beat without frame end");

  a_back_hdr_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_HDR |-> hdr_idx != 6'd0 && hdr_idx <= last_idx)
    else $error("header index out of range");

  a_back_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && state == ST_IDLE)
    else $error("command popped from an empty queue or while busy");

endmodule
